// File: rtl/lsf_pkg.sv
// ----------------------------------------------------------------------------
// lsf_pkg
// shared widths, status codes and controller/datapath interface types
// ----------------------------------------------------------------------------
package lsf_pkg;

    localparam int MAX_POINTS_DEF = 65536;
    localparam int CNT_W   = 17;
    localparam int SLOPE_W = 34;
    localparam int ICPT_W  = 48;
    localparam int R2_W    = 17;
    localparam int STAT_W  = 2;
    localparam int WIDE_W  = 128;
    localparam int OP_W    = 64;
    localparam int DIVN_W  = 96;
    localparam int SEL_W   = 4;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_FEW      = 2'd1;
    localparam logic [STAT_W-1:0] ST_NO_XSPRD = 2'd2;
    localparam logic [STAT_W-1:0] ST_TOO_MANY = 2'd3;

    // product schedule: even steps set the target, odd steps subtract; MS_RNUM and MS_RDEN only load their product
    localparam logic [SEL_W-1:0] MS_N_SX2  = 4'd0;
    localparam logic [SEL_W-1:0] MS_SX_SX  = 4'd1;
    localparam logic [SEL_W-1:0] MS_N_SY2  = 4'd2;
    localparam logic [SEL_W-1:0] MS_SY_SY  = 4'd3;
    localparam logic [SEL_W-1:0] MS_N_SXY  = 4'd4;
    localparam logic [SEL_W-1:0] MS_SX_SY  = 4'd5;
    localparam logic [SEL_W-1:0] MS_SY_SX2 = 4'd6;
    localparam logic [SEL_W-1:0] MS_SX_SXY = 4'd7;
    localparam logic [SEL_W-1:0] MS_RNUM   = 4'd8;
    localparam logic [SEL_W-1:0] MS_RDEN   = 4'd9;

    typedef struct packed {
        logic             acc_en;
        logic             mul_start;
        logic [SEL_W-1:0] mul_sel;
        logic             div_start;
        logic             div_icpt;
        logic             r2_start;
        logic             load_out;
    } lsf_cmd_t;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic r2_done;
        logic fit_err;
        logic out_free;
    } lsf_stat_t;

endpackage

// File: rtl/least_squares_line_fit_unit.sv
// ----------------------------------------------------------------------------
// least_squares_line_fit_unit
// least-squares line fit over a stream of signed 16-bit (x, y) pairs
// ----------------------------------------------------------------------------
// Pairs are taken one per cycle while intake is open and folded into exact
// sums. The pair marked tlast closes the set. The unit then stops taking
// pairs while one shared shift-add multiplier forms ten products. Unless the
// set is in error, a bit-serial divider then forms slope and intercept, and
// a bit-serial fraction step gives r^2. Intake reopens once the result is
// loaded into the output register, and stays closed while the previous result
// beat still waits there.
module least_squares_line_fit_unit import lsf_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // x_value, y_value
    input  logic         s_tlast,   // last_pair
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata    // slope_q16, intercept_q16, r_squared_q16, fit_status
);

    lsf_cmd_t  cmd;
    lsf_stat_t stat;

    lsf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .stat     (stat),
        .cmd      (cmd)
    );

    lsf_datapath #(.MAX_POINTS(MAX_POINTS)) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_tvalid (s_tvalid),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    assign s_tready = cmd.acc_en;

endmodule

// File: rtl/lsf_datapath.sv
// ----------------------------------------------------------------------------
// lsf_datapath
// sum accumulators, shift-add multiplier, restoring divider, r^2 fraction
// ----------------------------------------------------------------------------
module lsf_datapath import lsf_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  lsf_cmd_t     cmd,
    output lsf_stat_t    stat,
    input  logic         s_tvalid,
    input  logic [31:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata
);

    logic [CNT_W-1:0]         cnt_reg;
    logic signed [32:0]       sx_reg, sy_reg;
    logic [46:0]              sx2_reg, sy2_reg;
    logic signed [47:0]       sxy_reg;
    logic                     many_reg;

    logic signed [WIDE_W-1:0] sxx_reg, syy_reg, vxy_reg, inum_reg;
    logic [WIDE_W-1:0]        rnum_reg, rden_reg;

    logic [WIDE_W-1:0]        ma_reg, macc_reg;
    logic [OP_W-1:0]          mb_reg;
    logic                     mneg_reg, mbusy_reg, mapply_reg;
    logic [6:0]               mcnt_reg;
    logic [SEL_W-1:0]         msel_reg;

    logic [DIVN_W-1:0]        dn_reg, dq_reg;
    logic [OP_W-1:0]          drem_reg;
    logic                     dneg_reg, dbusy_reg, dapply_reg, dicpt_reg;
    logic [6:0]               dcnt_reg;

    logic                     rbusy_reg, rdone_reg;
    logic [4:0]               rcnt_reg;

    logic signed [SLOPE_W-1:0] slope_reg;
    logic signed [ICPT_W-1:0]  icpt_reg;
    logic [R2_W-1:0]           r2_reg;
    logic                      mvalid_reg;
    logic [103:0]              mdata_reg;

    logic signed [15:0]       x_in, y_in;
    logic signed [31:0]       pxx, pyy, pxy;
    logic signed [OP_W-1:0]   op_a, op_b;
    logic [OP_W-1:0]          a_mag, b_mag;
    logic signed [WIDE_W-1:0] base, mres, cur;
    logic [OP_W-1:0]          rem_sh;
    logic signed [WIDE_W-1:0] dnum;
    logic [WIDE_W-1:0]        dmag;
    logic [WIDE_W-1:0]        rsh;
    logic                     accept, few, xzero, err;
    logic [STAT_W-1:0]        code;
    logic [SLOPE_W-1:0]       slope_sat;
    logic [ICPT_W-1:0]        icpt_sat;

    assign x_in   = s_tdata[15:0];
    assign y_in   = s_tdata[31:16];
    assign pxx    = x_in * x_in;
    assign pyy    = y_in * y_in;
    assign pxy    = x_in * y_in;
    assign accept = s_tvalid && cmd.acc_en;

    always_comb begin
        op_a = '0;
        op_b = '0;
        unique case (cmd.mul_sel)
            MS_N_SX2:  begin op_a = OP_W'(cnt_reg); op_b = OP_W'(sx2_reg); end
            MS_SX_SX:  begin op_a = OP_W'(sx_reg);  op_b = OP_W'(sx_reg); end
            MS_N_SY2:  begin op_a = OP_W'(cnt_reg); op_b = OP_W'(sy2_reg); end
            MS_SY_SY:  begin op_a = OP_W'(sy_reg);  op_b = OP_W'(sy_reg); end
            MS_N_SXY:  begin op_a = OP_W'(cnt_reg); op_b = OP_W'(sxy_reg); end
            MS_SX_SY:  begin op_a = OP_W'(sx_reg);  op_b = OP_W'(sy_reg); end
            MS_SY_SX2: begin op_a = OP_W'(sy_reg);  op_b = OP_W'(sx2_reg); end
            MS_SX_SXY: begin op_a = OP_W'(sx_reg);  op_b = OP_W'(sxy_reg); end
            MS_RNUM:   begin op_a = vxy_reg[OP_W-1:0]; op_b = vxy_reg[OP_W-1:0]; end
            MS_RDEN:   begin op_a = sxx_reg[OP_W-1:0]; op_b = syy_reg[OP_W-1:0]; end
            default:   begin op_a = '0; op_b = '0; end
        endcase
        a_mag = op_a[OP_W-1] ? OP_W'(-op_a) : OP_W'(op_a);
        b_mag = op_b[OP_W-1] ? OP_W'(-op_b) : OP_W'(op_b);
    end

    always_comb begin
        unique case (msel_reg)
            MS_N_SX2, MS_SX_SX:   cur = sxx_reg;
            MS_N_SY2, MS_SY_SY:   cur = syy_reg;
            MS_N_SXY, MS_SX_SY:   cur = vxy_reg;
            MS_SY_SX2, MS_SX_SXY: cur = inum_reg;
            default:              cur = '0;
        endcase
        base = msel_reg[0] ? cur : '0;
        mres = (mneg_reg ^ msel_reg[0]) ? base - $signed(macc_reg)
                                        : base + $signed(macc_reg);
    end

    assign dnum   = cmd.div_icpt ? inum_reg : vxy_reg;
    assign dmag   = dnum[WIDE_W-1] ? WIDE_W'(-dnum) : WIDE_W'(dnum);
    assign rem_sh = {drem_reg[OP_W-2:0], dn_reg[DIVN_W-1]};
    assign rsh    = {rnum_reg[WIDE_W-2:0], 1'b0};

    always_comb begin
        if (dneg_reg) begin
            if (dq_reg > DIVN_W'({1'b1, {(SLOPE_W-1){1'b0}}}))
                slope_sat = {1'b1, {(SLOPE_W-1){1'b0}}};
            else
                slope_sat = SLOPE_W'(-dq_reg);
            if (dq_reg > DIVN_W'({1'b1, {(ICPT_W-1){1'b0}}}))
                icpt_sat = {1'b1, {(ICPT_W-1){1'b0}}};
            else
                icpt_sat = ICPT_W'(-dq_reg);
        end else begin
            if (dq_reg > DIVN_W'({1'b0, {(SLOPE_W-1){1'b1}}}))
                slope_sat = {1'b0, {(SLOPE_W-1){1'b1}}};
            else
                slope_sat = SLOPE_W'(dq_reg);
            if (dq_reg > DIVN_W'({1'b0, {(ICPT_W-1){1'b1}}}))
                icpt_sat = {1'b0, {(ICPT_W-1){1'b1}}};
            else
                icpt_sat = ICPT_W'(dq_reg);
        end
    end

    assign few   = cnt_reg < CNT_W'(2);
    assign xzero = sxx_reg == '0;
    assign err   = many_reg || few || xzero;
    always_comb begin
        if (many_reg)  code = ST_TOO_MANY;
        else if (few)  code = ST_FEW;
        else if (xzero) code = ST_NO_XSPRD;
        else           code = ST_OK;
    end

    // sums
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.load_out) begin
            cnt_reg  <= '0;
            sx_reg   <= '0;
            sy_reg   <= '0;
            sx2_reg  <= '0;
            sy2_reg  <= '0;
            sxy_reg  <= '0;
            many_reg <= 1'b0;
        end else if (accept) begin
            if (cnt_reg < CNT_W'(MAX_POINTS)) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                sx_reg  <= sx_reg + 33'(x_in);
                sy_reg  <= sy_reg + 33'(y_in);
                sx2_reg <= sx2_reg + 47'(unsigned'(pxx));
                sy2_reg <= sy2_reg + 47'(unsigned'(pyy));
                sxy_reg <= sxy_reg + 48'(pxy);
            end else begin
                many_reg <= 1'b1;
            end
        end
    end

    // multiplier
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mbusy_reg  <= 1'b0;
            mapply_reg <= 1'b0;
        end else begin
            mapply_reg <= 1'b0;
            if (cmd.mul_start) begin
                mbusy_reg <= 1'b1;
                mcnt_reg  <= 7'd64;
                ma_reg    <= WIDE_W'(a_mag);
                mb_reg    <= b_mag;
                macc_reg  <= '0;
                mneg_reg  <= op_a[OP_W-1] ^ op_b[OP_W-1];
                msel_reg  <= cmd.mul_sel;
            end else if (mbusy_reg) begin
                if (mb_reg[0])
                    macc_reg <= macc_reg + ma_reg;
                ma_reg   <= {ma_reg[WIDE_W-2:0], 1'b0};
                mb_reg   <= {1'b0, mb_reg[OP_W-1:1]};
                mcnt_reg <= mcnt_reg - 7'd1;
                if (mcnt_reg == 7'd1) begin
                    mbusy_reg  <= 1'b0;
                    mapply_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mapply_reg) begin
            unique case (msel_reg)
                MS_N_SX2, MS_SX_SX:   sxx_reg  <= mres;
                MS_N_SY2, MS_SY_SY:   syy_reg  <= mres;
                MS_N_SXY, MS_SX_SY:   vxy_reg  <= mres;
                MS_SY_SX2, MS_SX_SXY: inum_reg <= mres;
                MS_RNUM:              rnum_reg <= macc_reg;
                MS_RDEN:              rden_reg <= macc_reg;
                default:              ;
            endcase
        end else if (rbusy_reg && !(syy_reg == '0 || rnum_reg >= rden_reg)
                     && rcnt_reg != '0) begin
            rnum_reg <= (rsh >= rden_reg) ? rsh - rden_reg : rsh;
        end
    end

    // divider
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dbusy_reg  <= 1'b0;
            dapply_reg <= 1'b0;
        end else begin
            dapply_reg <= 1'b0;
            if (cmd.div_start) begin
                dbusy_reg <= 1'b1;
                dcnt_reg  <= 7'd96;
                dn_reg    <= {dmag[DIVN_W-17:0], 16'd0};
                dq_reg    <= '0;
                drem_reg  <= '0;
                dneg_reg  <= dnum[WIDE_W-1];
                dicpt_reg <= cmd.div_icpt;
            end else if (dbusy_reg) begin
                dn_reg <= {dn_reg[DIVN_W-2:0], 1'b0};
                if (rem_sh >= sxx_reg[OP_W-1:0]) begin
                    drem_reg <= rem_sh - sxx_reg[OP_W-1:0];
                    dq_reg   <= {dq_reg[DIVN_W-2:0], 1'b1};
                end else begin
                    drem_reg <= rem_sh;
                    dq_reg   <= {dq_reg[DIVN_W-2:0], 1'b0};
                end
                dcnt_reg <= dcnt_reg - 7'd1;
                if (dcnt_reg == 7'd1) begin
                    dbusy_reg  <= 1'b0;
                    dapply_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (dapply_reg) begin
            if (dicpt_reg)
                icpt_reg <= icpt_sat;
            else
                slope_reg <= slope_sat;
        end
    end

    // r^2 fraction bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rbusy_reg <= 1'b0;
            rdone_reg <= 1'b0;
        end else begin
            rdone_reg <= 1'b0;
            if (cmd.r2_start) begin
                rbusy_reg <= 1'b1;
                rcnt_reg  <= 5'd16;
                r2_reg    <= '0;
            end else if (rbusy_reg) begin
                if (syy_reg == '0 || rnum_reg >= rden_reg) begin
                    r2_reg    <= R2_W'(65536);
                    rbusy_reg <= 1'b0;
                    rdone_reg <= 1'b1;
                end else if (rcnt_reg == '0) begin
                    rbusy_reg <= 1'b0;
                    rdone_reg <= 1'b1;
                end else begin
                    r2_reg   <= {r2_reg[R2_W-2:0], rsh >= rden_reg};
                    rcnt_reg <= rcnt_reg - 5'd1;
                end
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mvalid_reg <= 1'b0;
        end else begin
            if (m_tready)
                mvalid_reg <= 1'b0;
            if (cmd.load_out) begin
                mvalid_reg <= 1'b1;
                if (err)
                    mdata_reg <= {3'd0, code, {(R2_W+ICPT_W+SLOPE_W){1'b0}}};
                else
                    mdata_reg <= {3'd0, code, r2_reg, icpt_reg, slope_reg};
            end
        end
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;

    assign stat.mul_done = mapply_reg;
    assign stat.div_done = dapply_reg;
    assign stat.r2_done  = rdone_reg;
    assign stat.fit_err  = err;
    assign stat.out_free = !mvalid_reg || m_tready;

endmodule

// File: rtl/lsf_ctrl.sv
// ----------------------------------------------------------------------------
// lsf_ctrl
// sequencer for accumulation, product schedule, divisions and r^2
// ----------------------------------------------------------------------------
module lsf_ctrl import lsf_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    input  logic      s_tlast,
    input  lsf_stat_t stat,
    output lsf_cmd_t  cmd
);

    localparam logic [3:0] S_ACC  = 4'd0;
    localparam logic [3:0] S_MUL  = 4'd1;
    localparam logic [3:0] S_MULW = 4'd2;
    localparam logic [3:0] S_CHK  = 4'd3;
    localparam logic [3:0] S_DS   = 4'd4;
    localparam logic [3:0] S_DSW  = 4'd5;
    localparam logic [3:0] S_DI   = 4'd6;
    localparam logic [3:0] S_DIW  = 4'd7;
    localparam logic [3:0] S_R2   = 4'd8;
    localparam logic [3:0] S_R2W  = 4'd9;
    localparam logic [3:0] S_OUT  = 4'd10;

    logic [3:0]       state_reg, state_next;
    logic [SEL_W-1:0] step_reg, step_next;

    always_comb begin
        state_next    = state_reg;
        step_next     = step_reg;
        cmd           = '0;
        cmd.mul_sel   = step_reg;
        unique case (state_reg)
            S_ACC: begin
                cmd.acc_en = 1'b1;
                step_next  = MS_N_SX2;
                if (s_tvalid && s_tlast)
                    state_next = S_MUL;
            end
            S_MUL: begin
                cmd.mul_start = 1'b1;
                state_next    = S_MULW;
            end
            S_MULW: begin
                if (stat.mul_done) begin
                    step_next  = step_reg + SEL_W'(1);
                    state_next = (step_reg == MS_RDEN) ? S_CHK : S_MUL;
                end
            end
            S_CHK:  state_next = stat.fit_err ? S_OUT : S_DS;
            S_DS: begin
                cmd.div_start = 1'b1;
                state_next    = S_DSW;
            end
            S_DSW:  if (stat.div_done) state_next = S_DI;
            S_DI: begin
                cmd.div_start = 1'b1;
                cmd.div_icpt  = 1'b1;
                state_next    = S_DIW;
            end
            S_DIW:  if (stat.div_done) state_next = S_R2;
            S_R2: begin
                cmd.r2_start = 1'b1;
                state_next   = S_R2W;
            end
            S_R2W:  if (stat.r2_done) state_next = S_OUT;
            S_OUT: begin
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_ACC;
                end
            end
            default: state_next = S_ACC;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_ACC;
            step_reg  <= MS_N_SX2;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the least-squares line fit unit
// ----------------------------------------------------------------------------
// Pair sets are streamed in with random idling on both sides. An exact-sum
// model of the fit runs on every accepted pair and queues the expected
// result beat. Each result beat is checked field by field against the
// oldest queued result. The sets cover single points, zero x spread, flat y,
// extreme values and a large slope and intercept.
module tb_top import lsf_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               last;
    } pair_t;

    typedef struct {
        logic [SLOPE_W-1:0] slope;
        logic [ICPT_W-1:0]  icpt;
        logic [R2_W-1:0]    r2;
        logic [STAT_W-1:0]  status;
    } fit_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [31:0]  s_tdata = '0;
    logic         s_tlast = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [103:0] m_tdata;

    least_squares_line_fit_unit DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    pair_t pair_q[$];
    fit_t  fit_q[$];
    int    error_count = 0;
    int    total_pairs = 0;
    int    sent_pairs = 0;
    int    fits_seen = 0;
    int    hold_cycles = 0;
    bit    hold_done = 0;

    // exact running sums
    longint n_pts, sx, sy, sxx_sum, syy_sum, sxy_sum;
    bit     overflow_set;

    function automatic logic [63:0] sat_q16(logic signed [191:0] v, int w);
        logic signed [191:0] lim;
        lim = 192'sd1 <<< (w - 1);
        if (v >= lim) return 64'(lim - 1);
        if (v < -lim) return 64'(-lim);
        return 64'(v);
    endfunction

    function automatic bit fold_pair(pair_t p, output fit_t r);
        logic signed [191:0] n, gx, gy, dxx, dyy, dxy, inum;
        logic [191:0] rn, rd;
        bit fire;
        if (n_pts < MAX_POINTS_DEF) begin
            n_pts++;
            sx += p.x;
            sy += p.y;
            sxx_sum += longint'(p.x) * p.x;
            syy_sum += longint'(p.y) * p.y;
            sxy_sum += longint'(p.x) * p.y;
        end else begin
            overflow_set = 1;
        end
        fire = p.last;
        r = '{default: '0};
        if (!fire) return 0;
        n = n_pts;
        gx = sx;
        gy = sy;
        if (overflow_set) r.status = ST_TOO_MANY;
        else if (n < 2) r.status = ST_FEW;
        else begin
            dxx = n * sxx_sum - gx * gx;
            dyy = n * syy_sum - gy * gy;
            dxy = n * sxy_sum - gx * gy;
            if (dxx == 0) r.status = ST_NO_XSPRD;
            else begin
                r.status = ST_OK;
                r.slope = SLOPE_W'(sat_q16((dxy <<< 16) / dxx, SLOPE_W));
                inum = gy * sxx_sum - gx * sxy_sum;
                r.icpt = ICPT_W'(sat_q16((inum <<< 16) / dxx, ICPT_W));
                if (dyy == 0) r.r2 = 17'd65536;
                else begin
                    rn = dxy * dxy;
                    rd = dxx * dyy;
                    r.r2 = (rn >= rd) ? 17'd65536 : R2_W'((rn << 16) / rd);
                end
            end
        end
        n_pts = 0; sx = 0; sy = 0; sxx_sum = 0; syy_sum = 0; sxy_sum = 0;
        overflow_set = 0;
        return 1;
    endfunction

    function automatic int phase_now();
        return (sent_pairs * 3) / (total_pairs + 1);
    endfunction

    // sender
    pair_t cur_pair;
    always @(posedge aclk) begin
        fit_t r;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                if (fold_pair(cur_pair, r)) fit_q.insert(fit_q.size(), r);
            end
            if (!s_tvalid || s_tready) begin
                if (pair_q.size() > 0 &&
                    !((phase_now() == 0 && $urandom_range(99) < 11) ||
                      (phase_now() == 1 && $urandom_range(99) < 66))) begin
                    cur_pair = pair_q.pop_front();
                    sent_pairs++;
                    s_tdata  <= {cur_pair.y, cur_pair.x};
                    s_tlast  <= cur_pair.last;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off after a few results
    always @(posedge aclk) begin
        if (aresetn && !hold_done && fits_seen >= 5) begin
            hold_cycles <= hold_cycles + 1;
            if (hold_cycles >= 3000) hold_done <= 1;
        end
    end

    // receiver
    always @(posedge aclk) begin
        fit_t e;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                fits_seen++;
                if (fit_q.size() == 0) begin
                    $error("result beat with no expected fit");
                    error_count++;
                end else begin
                    e = fit_q.pop_front();
                    if (m_tdata[33:0] !== e.slope) begin
                        $error("slope_q16 exp %h got %h", e.slope, m_tdata[33:0]);
                        error_count++;
                    end
                    if (m_tdata[81:34] !== e.icpt) begin
                        $error("intercept_q16 exp %h got %h", e.icpt, m_tdata[81:34]);
                        error_count++;
                    end
                    if (m_tdata[98:82] !== e.r2) begin
                        $error("r_squared_q16 exp %h got %h", e.r2, m_tdata[98:82]);
                        error_count++;
                    end
                    if (m_tdata[100:99] !== e.status) begin
                        $error("fit_status exp %h got %h", e.status, m_tdata[100:99]);
                        error_count++;
                    end
                end
            end
            if (fits_seen >= 5 && !hold_done) m_tready <= 1'b0;
            else if (phase_now() == 0) m_tready <= ($urandom_range(99) >= 66);
            else if (phase_now() == 1) m_tready <= ($urandom_range(99) >= 11);
            else m_tready <= 1'b1;
        end
    end

    task automatic add_pair(int x, int y, bit last);
        pair_t p;
        p.x = 16'(x);
        p.y = 16'(y);
        p.last = last;
        pair_q.insert(pair_q.size(), p);
    endtask

    initial begin
        int len, base, mode;
        n_pts = 0; sx = 0; sy = 0; sxx_sum = 0; syy_sum = 0; sxy_sum = 0;
        overflow_set = 0;
        // directed sets
        add_pair(5, 7, 1);                                  // single point
        add_pair(3, 1, 0); add_pair(3, 9, 1);               // zero x spread
        add_pair(-32768, -32768, 0); add_pair(32767, 32767, 1);
        add_pair(-32768, 32767, 0); add_pair(32767, -32768, 1);
        add_pair(1, 4, 0); add_pair(2, 4, 0); add_pair(9, 4, 1);   // flat y
        add_pair(32766, -32768, 0); add_pair(32767, 32767, 1);     // large slope and intercept
        add_pair(-32768, 0, 0); add_pair(-32767, 32767, 1);
        add_pair(0, 0, 0); add_pair(1, 2, 0); add_pair(2, 4, 0); add_pair(3, 7, 1);
        // random sets
        while (pair_q.size() < 400) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(30, 1) : $urandom_range(10, 2);
            mode = $urandom_range(5);
            base = $urandom_range(65535) - 32768;
            for (int i = 0; i < len; i++) begin
                case (mode)
                    0: add_pair(base, $urandom_range(65535), i == len - 1);
                    1: add_pair($urandom_range(65535), base, i == len - 1);
                    2: add_pair(base + $urandom_range(8), base * 3 + $urandom_range(40),
                                i == len - 1);
                    default: add_pair($urandom_range(65535), $urandom_range(65535),
                                      i == len - 1);
                endcase
            end
        end
        add_pair(1, 1, 0); add_pair(2, 3, 1);
        total_pairs = pair_q.size();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        wait (pair_q.size() == 0);
        @(posedge aclk);
        while (s_tvalid || fit_q.size() > 0) @(posedge aclk);
        repeat (2000) @(posedge aclk);
        if (error_count == 0 && fit_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #40ms;
        $display("DONE: errors detected");
        $finish;
    end
endmodule
